[src/rbsi_pkg.sv]
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants of the rigid body step integrator
// Event codes, controller states, command struct and fixed-point helpers.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int FracBitsDefault = 16;
   localparam int DtBits          = 16;
   localparam int WordBits        = 32;
   localparam int CfgIndexBits    = 3;

   typedef enum logic [2:0] {
      KIND_FORCE   = 3'd0,
      KIND_IMPULSE = 3'd1,
      KIND_TORQUE  = 3'd2,
      KIND_TWIST   = 3'd3,
      KIND_TICK    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      REG_INV_MASS  = 3'd0,
      REG_INV_IX    = 3'd1,
      REG_INV_IY    = 3'd2,
      REG_INV_IZ    = 3'd3,
      REG_GRAV_X    = 3'd4,
      REG_GRAV_Y    = 3'd5,
      REG_GRAV_Z    = 3'd6,
      REG_GRAV_ON   = 3'd7
   } reg_index_type;

   // One datapath operation per cycle; the sequencer walks these in order.
   typedef enum logic [3:0] {
      OP_CROSS_A,   // first half of the cross product terms
      OP_CROSS_B,   // second half, difference, accumulate
      OP_DIRECT,    // plain vector accumulate
      OP_ACC,       // a = g + F*m, vt = v*dt, imp = J*m
      OP_AT,        // at = a*dt, v += a*dt, alpha = T*I, kick = K*I
      OP_HALF,      // half = at*dt/2, aat = alpha*dt
      OP_SPIN,      // v += imp, w += aat + kick, move = vt + half
      OP_TURN       // turn = w*dt, clear sums
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CROSS,
      ST_TICK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic   load;     // capture request fields
      logic   run;      // perform op
      op_type op;
   } cmd_type;

   function automatic logic signed [WordBits-1:0] sat32(input logic signed [66:0] x);
      logic signed [66:0] hi;
      logic signed [66:0] lo;
      hi = 67'sd2147483647;
      lo = -67'sd2147483648;
      if (x > hi) return 32'sh7fffffff;
      else if (x < lo) return 32'sh80000000;
      else return x[WordBits-1:0];
   endfunction

endpackage

[src/rbsi_ctrl.sv]
// ----------------------------------------------------------------------------
// rbsi_ctrl: sequencer of the rigid body step integrator
// Accepts one request at a time and steps the datapath through its ops.
// ----------------------------------------------------------------------------
module rbsi_ctrl import rbsi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_kind,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      take;

   assign take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req_kind)
                  KIND_FORCE, KIND_IMPULSE: begin
                     state_in = ST_CROSS;
                     op_in    = OP_CROSS_A;
                  end
                  KIND_TORQUE, KIND_TWIST: begin
                     state_in = ST_CROSS;
                     op_in    = OP_DIRECT;
                  end
                  KIND_TICK: begin
                     state_in = ST_TICK;
                     op_in    = OP_ACC;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CROSS: begin
            if (op_ff == OP_CROSS_A) op_in = OP_CROSS_B;
            else state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (op_ff == OP_TURN) state_in = ST_OUT;
            else op_in = op_type'(op_ff + 4'd1);
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      cmd.load  = take;
      cmd.run   = (state_ff == ST_CROSS) || (state_ff == ST_TICK);
      cmd.op    = op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ACC;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

[src/rbsi_datapath.sv]
// ----------------------------------------------------------------------------
// rbsi_datapath: registers and arithmetic of the rigid body step integrator
// Three lanes, one per axis; each op uses at most four products per lane.
// ----------------------------------------------------------------------------
module rbsi_datapath import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [2:0]          req_kind,
   input  logic signed [31:0]  vec [3],
   input  logic signed [31:0]  pnt [3],
   input  logic [15:0]         req_step_time,
   input  logic [30:0]         inv_mass,
   input  logic [30:0]         inv_inertia [3],
   input  logic signed [31:0]  gravity [3],
   input  logic                gravity_on,
   output logic signed [31:0]  move [3],
   output logic signed [31:0]  turn [3]
);

   logic [2:0]         kind_ff;
   logic signed [31:0] vec_ff [3];
   logic signed [31:0] pnt_ff [3];
   logic [15:0]        dt_ff;

   logic signed [31:0] lv_ff [3], sr_ff [3], fs_ff [3], ts_ff [3], is_ff [3], ks_ff [3];
   logic signed [31:0] t0_ff [3], t1_ff [3], t2_ff [3], t3_ff [3];
   logic signed [63:0] pa_ff [3];

   function automatic logic signed [66:0] shr_f(input logic signed [66:0] p,
                                                input int s);
      return p >>> s;
   endfunction

   function automatic logic signed [31:0] mul_u(input logic signed [31:0] a,
                                                input logic [30:0] f);
      logic signed [66:0] p;
      p = 67'(a) * $signed({36'd0, f});
      return sat32(shr_f(p, FRAC_BITS));
   endfunction

   function automatic logic signed [31:0] mul_dt(input logic signed [31:0] a,
                                                 input logic [15:0] d);
      logic signed [66:0] p;
      p = 67'(a) * $signed({51'd0, d});
      return sat32(shr_f(p, DtBits));
   endfunction

   function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return sat32(67'(a) + 67'(b));
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         vec_ff  <= vec;
         pnt_ff  <= pnt;
         dt_ff   <= req_step_time;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      logic signed [63:0] pb;
      logic signed [31:0] cr;
      logic               is_force;
      assign is_force = (kind_ff == KIND_FORCE);
      assign pb = 64'(pnt_ff[K]) * 64'(vec_ff[J]);
      assign cr = sat32(shr_f(67'(pa_ff[i]) - 67'(pb), FRAC_BITS));

      always_ff @(posedge clock) begin
         if (cmd.run && cmd.op == OP_CROSS_A)
            pa_ff[i] <= 64'(pnt_ff[J]) * 64'(vec_ff[K]);
         unique case (cmd.op)
            OP_ACC: begin
               t0_ff[i] <= add_s(gravity_on ? gravity[i] : 32'sd0,
                                 mul_u(fs_ff[i], inv_mass));
               t1_ff[i] <= mul_dt(lv_ff[i], dt_ff);
               t2_ff[i] <= mul_u(is_ff[i], inv_mass);
            end
            OP_AT: begin
               t0_ff[i] <= mul_dt(t0_ff[i], dt_ff);
               t3_ff[i] <= mul_u(ts_ff[i], inv_inertia[i]);
               pa_ff[i] <= 64'(mul_u(ks_ff[i], inv_inertia[i]));
            end
            OP_HALF: begin
               t0_ff[i] <= mul_dt(t0_ff[i], dt_ff) >>> 1;
               t3_ff[i] <= mul_dt(t3_ff[i], dt_ff);
            end
            default: ;
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[i] <= '0; sr_ff[i] <= '0; fs_ff[i] <= '0;
            ts_ff[i] <= '0; is_ff[i] <= '0; ks_ff[i] <= '0;
         end else if (cmd.run) begin
            unique case (cmd.op)
               OP_CROSS_B: begin
                  if (is_force) begin
                     fs_ff[i] <= add_s(fs_ff[i], vec_ff[i]);
                     ts_ff[i] <= add_s(ts_ff[i], cr);
                  end else begin
                     is_ff[i] <= add_s(is_ff[i], vec_ff[i]);
                     ks_ff[i] <= add_s(ks_ff[i], cr);
                  end
               end
               OP_DIRECT: begin
                  if (kind_ff == KIND_TORQUE) ts_ff[i] <= add_s(ts_ff[i], vec_ff[i]);
                  else ks_ff[i] <= add_s(ks_ff[i], vec_ff[i]);
               end
               OP_AT: begin
                  lv_ff[i] <= add_s(lv_ff[i], mul_dt(t0_ff[i], dt_ff));
               end
               OP_SPIN: begin
                  lv_ff[i] <= add_s(lv_ff[i], t2_ff[i]);
                  sr_ff[i] <= add_s(add_s(sr_ff[i], t3_ff[i]), pa_ff[i][31:0]);
               end
               OP_TURN: begin
                  fs_ff[i] <= '0; ts_ff[i] <= '0; is_ff[i] <= '0; ks_ff[i] <= '0;
               end
               default: ;
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.run && cmd.op == OP_SPIN)
            move[i] <= add_s(t1_ff[i], t0_ff[i]);
         if (cmd.run && cmd.op == OP_TURN)
            turn[i] <= mul_dt(sr_ff[i], dt_ff);
      end
   end

endmodule

[src/rigid_body_step_integrator.sv]
// ----------------------------------------------------------------------------
// rigid_body_step_integrator: step integrator for one body
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage: the requester presents one event on req_* with req_valid; it is taken
// at a clock edge where req_stall is low. Force, impulse, torque and instant
// torque requests only update accumulators and give no response; a force or
// impulse steps through OP_CROSS_A then OP_CROSS_B, a torque or twist through
// OP_DIRECT only. A tick request runs five sequencer steps and then holds the
// position and rotation deltas on rsp_* with rsp_valid until an edge where
// rsp_stall is low. One request is in flight at a time. Unused kinds are
// swallowed. Configuration is written through csr_* (always ready); the user
// must write it only while the block is idle, which the block itself does not
// enforce. Synchronous reset clears velocities, accumulators and the sequencer,
// and restores register defaults (unit inverses, gravity -9.8 on y).
// ----------------------------------------------------------------------------
module rigid_body_step_integrator import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_kind,
   input  logic signed [31:0]       req_vector_x,
   input  logic signed [31:0]       req_vector_y,
   input  logic signed [31:0]       req_vector_z,
   input  logic signed [31:0]       req_point_x,
   input  logic signed [31:0]       req_point_y,
   input  logic signed [31:0]       req_point_z,
   input  logic [15:0]              req_step_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_move_x,
   output logic signed [31:0]       rsp_move_y,
   output logic signed [31:0]       rsp_move_z,
   output logic signed [31:0]       rsp_turn_x,
   output logic signed [31:0]       rsp_turn_y,
   output logic signed [31:0]       rsp_turn_z,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CfgIndexBits-1:0]  csr_index,
   input  logic [31:0]              csr_data
);

   logic [30:0]        inv_mass_ff;
   logic [30:0]        inv_i_ff [3];
   logic signed [31:0] grav_ff [3];
   logic               grav_on_ff;
   cmd_type            cmd;
   logic signed [31:0] vec [3], pnt [3], move [3], turn [3];

   assign csr_ready = 1'b1;
   assign vec = '{req_vector_x, req_vector_y, req_vector_z};
   assign pnt = '{req_point_x, req_point_y, req_point_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff <= 31'd65536;
         inv_i_ff    <= '{31'd65536, 31'd65536, 31'd65536};
         grav_ff     <= '{32'sd0, -32'sd642253, 32'sd0};
         grav_on_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_INV_MASS: inv_mass_ff <= csr_data[30:0];
            REG_INV_IX:   inv_i_ff[0] <= csr_data[30:0];
            REG_INV_IY:   inv_i_ff[1] <= csr_data[30:0];
            REG_INV_IZ:   inv_i_ff[2] <= csr_data[30:0];
            REG_GRAV_X:   grav_ff[0]  <= csr_data;
            REG_GRAV_Y:   grav_ff[1]  <= csr_data;
            REG_GRAV_Z:   grav_ff[2]  <= csr_data;
            REG_GRAV_ON:  grav_on_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   rbsi_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind,
      .rsp_valid, .rsp_stall, .cmd
   );

   rbsi_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .req_kind, .vec, .pnt, .req_step_time,
      .inv_mass(inv_mass_ff), .inv_inertia(inv_i_ff), .gravity(grav_ff),
      .gravity_on(grav_on_ff), .move, .turn
   );

   assign rsp_move_x = move[0];
   assign rsp_move_y = move[1];
   assign rsp_move_z = move[2];
   assign rsp_turn_x = turn[0];
   assign rsp_turn_y = turn[1];
   assign rsp_turn_z = turn[2];

   // A response is never shown while a request can be taken.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("response valid while input open");

   // Once a response is taken the block is idle again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid && !req_stall)
      else $error("block not idle after response");

   // A stalled response keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_move_y) && $stable(rsp_turn_y))
      else $error("stalled response changed");

endmodule
